// ===== hdl/lldaf_pkg.sv =====
`timescale 1ns / 1ps

package lldaf_pkg;

   localparam int WORKERS_DEFAULT     = 8;
   localparam int PIN_ENTRIES_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int SOURCE_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 4;

   localparam logic MODE_TASK = 1'b0;
   localparam logic MODE_DONE = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIFO_KEEP       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_WORKERS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESERVED_WORKER = 2'd2;

   localparam logic       FIFO_KEEP_RESET       = 1'b1;
   localparam logic [3:0] ACTIVE_WORKERS_RESET  = 4'd8;
   localparam logic [2:0] RESERVED_WORKER_RESET = 3'd1;

   typedef enum logic [2:0] {
      STATUS_DISPATCHED = 3'd0,
      STATUS_NO_WORKER  = 3'd1,
      STATUS_UNPINNED   = 3'd2,
      STATUS_COMPLETION = 3'd3,
      STATUS_UNKNOWN    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIN_SCAN,
      ST_DECIDE,
      ST_LOAD_SCAN,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                    mode;
      logic [SOURCE_WIDTH-1:0] source_id;
      logic [2:0]              done_worker;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [2:0] target_worker;
      logic       via_affinity;
   } rsp_type;

endpackage

// ===== hdl/lldaf_ram.sv =====
`timescale 1ns / 1ps

module lldaf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/least_loaded_dispatch_affinity_unit.sv =====
`timescale 1ns / 1ps

// Task dispatcher with per-source worker affinity.
// The req channel takes one item per task arrival or task completion; the rsp
// channel returns exactly one item for each, in order. Both use valid/stall.
// The csr channel writes fifo_keep, active_workers and reserved_worker; csr_ready
// is always high, and registers should be written only while no item is in work.
// Each item first scans the affinity table, one entry per cycle through the pin
// memory read port. A new task that needs a search then scans the loads of the
// first min(active_workers, WORKERS) workers, one per cycle through the load
// memory read port. Affinity hits and completions instead do a read and a write
// of one load. The next item is accepted in the cycle after the previous result
// at the earliest; req_stall is high while an item is in work.
// Results sit in an output register, so the next item is accepted while a result
// waits; a held rsp_stall only delays the end of that next item.
// Reset clears all loads through a pass over every worker, during which req_stall
// stays high, clears every affinity entry at once and restores register defaults.

module least_loaded_dispatch_affinity_unit #(
   parameter int WORKERS     = lldaf_pkg::WORKERS_DEFAULT,
   parameter int PIN_ENTRIES = lldaf_pkg::PIN_ENTRIES_DEFAULT,
   parameter int COUNT_WIDTH = lldaf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  lldaf_pkg::req_type                       req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output lldaf_pkg::rsp_type                       rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [lldaf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [lldaf_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int WAW   = $clog2(WORKERS);
   localparam int WW1   = $clog2(WORKERS + 1);
   localparam int LW    = (WW1 > 4) ? WW1 : 4;
   localparam int PAW   = (PIN_ENTRIES > 1) ? $clog2(PIN_ENTRIES) : 1;
   localparam int PW1   = $clog2(PIN_ENTRIES + 1);
   localparam int SRC_W = lldaf_pkg::SOURCE_WIDTH;
   localparam int PIN_W = SRC_W + WAW + COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   lldaf_pkg::state_type     state_ff, state_in;
   logic                     fifo_keep_ff, fifo_keep_in;
   logic [3:0]               active_ff, active_in;
   logic [2:0]               reserved_ff, reserved_in;
   logic [PIN_ENTRIES-1:0]   pin_valid_ff, pin_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   lldaf_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   lldaf_pkg::req_type       item_ff, item_in;
   logic [PW1-1:0]           pin_idx_ff, pin_idx_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic [PAW-1:0]           chk_idx_ff, chk_idx_in;
   logic                     hit_ff, hit_in;
   logic [PAW-1:0]           hit_idx_ff, hit_idx_in;
   logic [WAW-1:0]           hit_worker_ff, hit_worker_in;
   logic [COUNT_WIDTH-1:0]   hit_count_ff, hit_count_in;
   logic                     free_ff, free_in;
   logic [PAW-1:0]           free_idx_ff, free_idx_in;
   logic [LW-1:0]            wk_idx_ff, wk_idx_in;
   logic                     lchk_vld_ff, lchk_vld_in;
   logic [WAW-1:0]           lchk_idx_ff, lchk_idx_in;
   logic                     found_ff, found_in;
   logic [WAW-1:0]           best_ff, best_in;
   logic [COUNT_WIDTH-1:0]   best_load_ff, best_load_in;
   logic [WAW-1:0]           ld_addr_ff, ld_addr_in;
   lldaf_pkg::status_type    res_status_ff, res_status_in;
   logic [WAW-1:0]           res_target_ff, res_target_in;
   logic                     res_via_ff, res_via_in;

   logic                     load_wr_en;
   logic [WAW-1:0]           load_wr_addr;
   logic [COUNT_WIDTH-1:0]   load_wr_data;
   logic                     load_rd_en;
   logic [WAW-1:0]           load_rd_addr;
   logic [COUNT_WIDTH-1:0]   load_rd_data;
   logic                     pin_wr_en;
   logic [PAW-1:0]           pin_wr_addr;
   logic [PIN_W-1:0]         pin_wr_data;
   logic                     pin_rd_en;
   logic [PAW-1:0]           pin_rd_addr;
   logic [PIN_W-1:0]         pin_rd_data;

   logic [SRC_W-1:0]         rd_source;
   logic [WAW-1:0]           rd_worker;
   logic [COUNT_WIDTH-1:0]   rd_count;
   logic [LW-1:0]            lim;
   logic [COUNT_WIDTH-1:0]   dec_count;
   logic [PAW-1:0]           new_entry;

   assign rd_source = pin_rd_data[PIN_W-1 -: SRC_W];
   assign rd_worker = pin_rd_data[COUNT_WIDTH +: WAW];
   assign rd_count  = pin_rd_data[COUNT_WIDTH-1:0];
   assign lim       = (LW'(active_ff) < LW'(WORKERS)) ? LW'(active_ff) : LW'(WORKERS);
   assign dec_count = (hit_count_ff == '0) ? '0 : hit_count_ff - COUNT_WIDTH'(1);
   assign new_entry = hit_ff ? hit_idx_ff : free_idx_ff;

   assign req_stall = (state_ff != lldaf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   lldaf_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (WORKERS)
   ) u_load_ram (
      .clock   (clock),
      .wr_en   (load_wr_en),
      .wr_addr (load_wr_addr),
      .wr_data (load_wr_data),
      .rd_en   (load_rd_en),
      .rd_addr (load_rd_addr),
      .rd_data (load_rd_data)
   );

   lldaf_ram #(
      .WIDTH (PIN_W),
      .DEPTH (PIN_ENTRIES)
   ) u_pin_ram (
      .clock   (clock),
      .wr_en   (pin_wr_en),
      .wr_addr (pin_wr_addr),
      .wr_data (pin_wr_data),
      .rd_en   (pin_rd_en),
      .rd_addr (pin_rd_addr),
      .rd_data (pin_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      fifo_keep_in  = fifo_keep_ff;
      active_in     = active_ff;
      reserved_in   = reserved_ff;
      pin_valid_in  = pin_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      item_in       = item_ff;
      pin_idx_in    = pin_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_worker_in = hit_worker_ff;
      hit_count_in  = hit_count_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      wk_idx_in     = wk_idx_ff;
      lchk_vld_in   = 1'b0;
      lchk_idx_in   = lchk_idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_load_in  = best_load_ff;
      ld_addr_in    = ld_addr_ff;
      res_status_in = res_status_ff;
      res_target_in = res_target_ff;
      res_via_in    = res_via_ff;

      load_wr_en   = 1'b0;
      load_wr_addr = ld_addr_ff;
      load_wr_data = '0;
      load_rd_en   = 1'b0;
      load_rd_addr = ld_addr_ff;
      pin_wr_en    = 1'b0;
      pin_wr_addr  = hit_idx_ff;
      pin_wr_data  = {item_ff.source_id, hit_worker_ff, hit_count_ff};
      pin_rd_en    = 1'b0;
      pin_rd_addr  = pin_idx_ff[PAW-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            lldaf_pkg::CSR_FIFO_KEEP: begin
               fifo_keep_in = csr_data[0];
            end
            lldaf_pkg::CSR_ACTIVE_WORKERS: begin
               active_in = csr_data[3:0];
            end
            lldaf_pkg::CSR_RESERVED_WORKER: begin
               reserved_in = csr_data[2:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         lldaf_pkg::ST_CLEAR: begin
            load_wr_en   = 1'b1;
            load_wr_addr = wk_idx_ff[WAW-1:0];
            load_wr_data = '0;
            wk_idx_in    = wk_idx_ff + LW'(1);
            if (wk_idx_ff == LW'(WORKERS - 1)) begin
               state_in = lldaf_pkg::ST_IDLE;
            end
         end
         lldaf_pkg::ST_IDLE: begin
            if (req_valid) begin
               item_in    = req_data;
               pin_idx_in = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               state_in   = lldaf_pkg::ST_PIN_SCAN;
            end
         end
         lldaf_pkg::ST_PIN_SCAN: begin
            if (pin_idx_ff < PW1'(PIN_ENTRIES)) begin
               pin_rd_en   = 1'b1;
               pin_rd_addr = pin_idx_ff[PAW-1:0];
               pin_idx_in  = pin_idx_ff + PW1'(1);
               chk_vld_in  = 1'b1;
               chk_idx_in  = pin_idx_ff[PAW-1:0];
            end
            if (chk_vld_ff) begin
               if (pin_valid_ff[chk_idx_ff]) begin
                  if (rd_source == item_ff.source_id && !hit_ff) begin
                     hit_in        = 1'b1;
                     hit_idx_in    = chk_idx_ff;
                     hit_worker_in = rd_worker;
                     hit_count_in  = rd_count;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
            if (pin_idx_ff == PW1'(PIN_ENTRIES) && !chk_vld_ff) begin
               state_in = lldaf_pkg::ST_DECIDE;
            end
         end
         lldaf_pkg::ST_DECIDE: begin
            res_via_in    = 1'b0;
            res_target_in = '0;
            if (item_ff.mode == lldaf_pkg::MODE_TASK) begin
               if (hit_ff && fifo_keep_ff) begin
                  pin_wr_en     = 1'b1;
                  pin_wr_addr   = hit_idx_ff;
                  pin_wr_data   = {item_ff.source_id, hit_worker_ff,
                                   (hit_count_ff == CNT_MAX) ? hit_count_ff :
                                   hit_count_ff + COUNT_WIDTH'(1)};
                  res_status_in = lldaf_pkg::STATUS_DISPATCHED;
                  res_target_in = hit_worker_ff;
                  res_via_in    = 1'b1;
                  ld_addr_in    = hit_worker_ff;
                  state_in      = lldaf_pkg::ST_LOAD_RD;
               end else begin
                  wk_idx_in = '0;
                  found_in  = 1'b0;
                  state_in  = lldaf_pkg::ST_LOAD_SCAN;
               end
            end else begin
               res_status_in = hit_ff ? lldaf_pkg::STATUS_COMPLETION :
                               lldaf_pkg::STATUS_UNKNOWN;
               if (hit_ff) begin
                  pin_wr_en   = 1'b1;
                  pin_wr_addr = hit_idx_ff;
                  pin_wr_data = {item_ff.source_id, hit_worker_ff, dec_count};
                  if (dec_count == '0) begin
                     pin_valid_in[hit_idx_ff] = 1'b0;
                  end
               end
               if (LW'(item_ff.done_worker) < LW'(WORKERS)) begin
                  ld_addr_in = WAW'(item_ff.done_worker);
                  state_in   = lldaf_pkg::ST_LOAD_RD;
               end else begin
                  state_in = lldaf_pkg::ST_FINISH;
               end
            end
         end
         lldaf_pkg::ST_LOAD_SCAN: begin
            if (wk_idx_ff < lim) begin
               load_rd_en   = 1'b1;
               load_rd_addr = wk_idx_ff[WAW-1:0];
               wk_idx_in    = wk_idx_ff + LW'(1);
               lchk_vld_in  = 1'b1;
               lchk_idx_in  = wk_idx_ff[WAW-1:0];
            end
            if (lchk_vld_ff && LW'(lchk_idx_ff) != LW'(reserved_ff)) begin
               if (!found_ff || load_rd_data < best_load_ff) begin
                  found_in     = 1'b1;
                  best_in      = lchk_idx_ff;
                  best_load_in = load_rd_data;
               end
            end
            if (wk_idx_ff >= lim && !lchk_vld_ff) begin
               state_in = lldaf_pkg::ST_FINISH;
               if (!found_ff) begin
                  res_status_in = lldaf_pkg::STATUS_NO_WORKER;
               end else begin
                  load_wr_en    = 1'b1;
                  load_wr_addr  = best_ff;
                  load_wr_data  = (best_load_ff == CNT_MAX) ? best_load_ff :
                                  best_load_ff + COUNT_WIDTH'(1);
                  res_target_in = best_ff;
                  if (hit_ff || free_ff) begin
                     pin_wr_en               = 1'b1;
                     pin_wr_addr             = new_entry;
                     pin_wr_data             = {item_ff.source_id, best_ff,
                                                COUNT_WIDTH'(1)};
                     pin_valid_in[new_entry] = 1'b1;
                     res_status_in           = lldaf_pkg::STATUS_DISPATCHED;
                  end else begin
                     res_status_in = lldaf_pkg::STATUS_UNPINNED;
                  end
               end
            end
         end
         lldaf_pkg::ST_LOAD_RD: begin
            load_rd_en   = 1'b1;
            load_rd_addr = ld_addr_ff;
            state_in     = lldaf_pkg::ST_LOAD_WR;
         end
         lldaf_pkg::ST_LOAD_WR: begin
            load_wr_en   = 1'b1;
            load_wr_addr = ld_addr_ff;
            if (item_ff.mode == lldaf_pkg::MODE_TASK) begin
               load_wr_data = (load_rd_data == CNT_MAX) ? load_rd_data :
                              load_rd_data + COUNT_WIDTH'(1);
            end else begin
               load_wr_data = (load_rd_data == '0) ? '0 :
                              load_rd_data - COUNT_WIDTH'(1);
            end
            state_in = lldaf_pkg::ST_FINISH;
         end
         lldaf_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = res_status_ff;
               rsp_data_in.target_worker = 3'(res_target_ff);
               rsp_data_in.via_affinity  = res_via_ff;
               state_in                  = lldaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lldaf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lldaf_pkg::ST_CLEAR;
         fifo_keep_ff <= lldaf_pkg::FIFO_KEEP_RESET;
         active_ff    <= lldaf_pkg::ACTIVE_WORKERS_RESET;
         reserved_ff  <= lldaf_pkg::RESERVED_WORKER_RESET;
         pin_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         lchk_vld_ff  <= 1'b0;
         wk_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         fifo_keep_ff <= fifo_keep_in;
         active_ff    <= active_in;
         reserved_ff  <= reserved_in;
         pin_valid_ff <= pin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         lchk_vld_ff  <= lchk_vld_in;
         wk_idx_ff    <= wk_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      item_ff       <= item_in;
      pin_idx_ff    <= pin_idx_in;
      chk_idx_ff    <= chk_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_worker_ff <= hit_worker_in;
      hit_count_ff  <= hit_count_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      lchk_idx_ff   <= lchk_idx_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_load_ff  <= best_load_in;
      ld_addr_ff    <= ld_addr_in;
      res_status_ff <= res_status_in;
      res_target_ff <= res_target_in;
      res_via_ff    <= res_via_in;
   end

`ifndef SYNTHESIS
   a_best_not_reserved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lldaf_pkg::ST_LOAD_SCAN && found_ff)
      |-> (LW'(best_ff) != LW'(reserved_ff)))
      else $error("least-loaded search picked the reserved worker");

   a_pins_change_in_decision: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lldaf_pkg::ST_DECIDE && state_ff != lldaf_pkg::ST_LOAD_SCAN)
      |=> $stable(pin_valid_ff))
      else $error("affinity valid bits changed outside a decision step");

   a_scans_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lldaf_pkg::ST_FINISH) |-> (!chk_vld_ff && !lchk_vld_ff))
      else $error("result issued while a scan read was still in flight");

   a_via_only_dispatched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.via_affinity)
      |-> (rsp_data_ff.status == lldaf_pkg::STATUS_DISPATCHED))
      else $error("affinity flag set on a result that is not a dispatch");
`endif

endmodule

// ===== test/dispatch_checker.sv =====
`timescale 1ns / 1ps

module dispatch_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  lldaf_pkg::req_type                    req_data,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  lldaf_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [lldaf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lldaf_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                    fail_count,
   output int                                    pending_count
);

   localparam int WORKER_COUNT = lldaf_pkg::WORKERS_DEFAULT;
   localparam int PIN_COUNT    = lldaf_pkg::PIN_ENTRIES_DEFAULT;
   localparam int LOAD_WIDTH   = lldaf_pkg::COUNT_WIDTH_DEFAULT;
   localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

   bit                  keep_affinity;
   bit [3:0]            active_count;
   bit [2:0]            reserved_index;

   bit [LOAD_WIDTH-1:0] worker_load  [WORKER_COUNT];
   bit                  pin_used     [PIN_COUNT];
   bit [15:0]           pin_src      [PIN_COUNT];
   bit [2:0]            pin_target   [PIN_COUNT];
   bit [LOAD_WIDTH-1:0] pin_pending  [PIN_COUNT];

   lldaf_pkg::rsp_type awaited_outcomes [$];

   function automatic bit [LOAD_WIDTH-1:0] bump(input bit [LOAD_WIDTH-1:0] value);
      return (value == LOAD_MAX) ? value : value + 1'b1;
   endfunction

   function automatic int lookup_pin(input bit [15:0] source);
      for (int k = 0; k < PIN_COUNT; k++)
         if (pin_used[k] && pin_src[k] == source)
            return k;
      return -1;
   endfunction

   function automatic lldaf_pkg::rsp_type next_dispatch_outcome(input lldaf_pkg::req_type item);
      lldaf_pkg::rsp_type outcome;
      int      entry;
      int      limit;
      int      best;
      bit      found;
      outcome = '{status: lldaf_pkg::STATUS_DISPATCHED, target_worker: 3'd0,
                  via_affinity: 1'b0};
      entry   = lookup_pin(item.source_id);
      if (item.mode == lldaf_pkg::MODE_TASK) begin
         if (entry >= 0 && keep_affinity) begin
            pin_pending[entry]   = bump(pin_pending[entry]);
            outcome.target_worker = pin_target[entry];
            outcome.via_affinity  = 1'b1;
         end else begin
            limit = (active_count < WORKER_COUNT) ? int'(active_count) : WORKER_COUNT;
            best  = 0;
            found = 1'b0;
            for (int w = 0; w < limit; w++) begin
               if (w != reserved_index && (!found || worker_load[w] < worker_load[best])) begin
                  best  = w;
                  found = 1'b1;
               end
            end
            if (!found) begin
               outcome.status = lldaf_pkg::STATUS_NO_WORKER;
            end else begin
               outcome.target_worker = best[2:0];
               if (entry < 0) begin
                  for (int k = PIN_COUNT - 1; k >= 0; k--)
                     if (!pin_used[k])
                        entry = k;
               end
               if (entry >= 0) begin
                  pin_used[entry]    = 1'b1;
                  pin_src[entry]     = item.source_id;
                  pin_target[entry]  = best[2:0];
                  pin_pending[entry] = LOAD_WIDTH'(1);
               end else begin
                  outcome.status = lldaf_pkg::STATUS_UNPINNED;
               end
            end
         end
         if (outcome.status != lldaf_pkg::STATUS_NO_WORKER)
            worker_load[outcome.target_worker] = bump(worker_load[outcome.target_worker]);
      end else begin
         if (worker_load[item.done_worker] != 0)
            worker_load[item.done_worker] = worker_load[item.done_worker] - 1'b1;
         if (entry >= 0) begin
            if (pin_pending[entry] != 0)
               pin_pending[entry] = pin_pending[entry] - 1'b1;
            if (pin_pending[entry] == 0)
               pin_used[entry] = 1'b0;
            outcome.status = lldaf_pkg::STATUS_COMPLETION;
         end else begin
            outcome.status = lldaf_pkg::STATUS_UNKNOWN;
         end
      end
      return outcome;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      lldaf_pkg::rsp_type want;
      if (reset) begin
         keep_affinity  = lldaf_pkg::FIFO_KEEP_RESET;
         active_count   = lldaf_pkg::ACTIVE_WORKERS_RESET;
         reserved_index = lldaf_pkg::RESERVED_WORKER_RESET;
         for (int w = 0; w < WORKER_COUNT; w++)
            worker_load[w] = '0;
         for (int k = 0; k < PIN_COUNT; k++)
            pin_used[k] = 1'b0;
         awaited_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lldaf_pkg::CSR_FIFO_KEEP:       keep_affinity  = csr_data[0];
               lldaf_pkg::CSR_ACTIVE_WORKERS:  active_count   = csr_data[3:0];
               lldaf_pkg::CSR_RESERVED_WORKER: reserved_index = csr_data[2:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d worker %0d",
                        $time, rsp_data.status, rsp_data.target_worker);
               fail_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               compare_field("status", want.status, rsp_data.status);
               compare_field("target_worker", want.target_worker, rsp_data.target_worker);
               compare_field("via_affinity", want.via_affinity, rsp_data.via_affinity);
            end
         end
         if (req_valid && !req_stall)
            awaited_outcomes = {awaited_outcomes, next_dispatch_outcome(req_data)};
      end
      pending_count = awaited_outcomes.size();
   end

endmodule

// ===== test/least_loaded_dispatch_affinity_unit_tb.sv =====
`timescale 1ns / 1ps

module least_loaded_dispatch_affinity_unit_tb;

   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 237;
   localparam int POOL_SIZE       = 20;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int TAIL_CYCLES     = 40;
   localparam int SRC_W           = lldaf_pkg::SOURCE_WIDTH;
   localparam int CSR_W           = lldaf_pkg::CSR_DATA_WIDTH;

   typedef struct packed {
      logic [SRC_W-1:0] source;
      logic [2:0]       worker;
   } running_type;

   logic                                  clock;
   logic                                  reset     = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   lldaf_pkg::req_type                    req_data  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   lldaf_pkg::rsp_type                    rsp_data;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [lldaf_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_W-1:0]                      csr_data  = '0;

   int fail_count;
   int pending_count;
   int send_idle_pct = 23;
   int recv_idle_pct = 57;
   int quiet_cycles  = 0;

   logic [SRC_W-1:0]   source_pool [POOL_SIZE];
   lldaf_pkg::req_type issued_q  [$];
   running_type        running_q [$];
   lldaf_pkg::req_type finished_req;

   least_loaded_dispatch_affinity_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dispatch_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // Tasks in flight are tracked from the results so that completions name real work.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall && issued_q.size() != 0) begin
            finished_req = issued_q.pop_front();
            if (finished_req.mode == lldaf_pkg::MODE_TASK &&
                (rsp_data.status == lldaf_pkg::STATUS_DISPATCHED ||
                 rsp_data.status == lldaf_pkg::STATUS_UNPINNED))
               running_q = {running_q, running_type'{source: finished_req.source_id,
                                                     worker: rsp_data.target_worker}};
         end
         if (req_valid && !req_stall)
            issued_q = {issued_q, req_data};
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(input logic mode, input logic [SRC_W-1:0] source,
                            input logic [2:0] worker);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data           <= '{mode: mode, source_id: source, done_worker: worker};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle_outcomes();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_count != 0);
   endtask

   task automatic program_registers(input logic [CSR_W-1:0] keep_value,
                                    input logic [CSR_W-1:0] active_value,
                                    input logic [CSR_W-1:0] reserved_value);
      logic [CSR_W-1:0]                      values  [3];
      logic [lldaf_pkg::CSR_INDEX_WIDTH-1:0] indexes [3];
      values  = '{keep_value, active_value, reserved_value};
      indexes = '{lldaf_pkg::CSR_FIFO_KEEP, lldaf_pkg::CSR_ACTIVE_WORKERS,
                  lldaf_pkg::CSR_RESERVED_WORKER};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[k];
         csr_data  <= values[k];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SRC_W-1:0] pick_source();
      if ($urandom_range(99) < 85)
         return source_pool[$urandom_range(POOL_SIZE - 1)];
      return SRC_W'($urandom_range(16'hFFFF));
   endfunction

   task automatic run_phase(input int phase);
      int          pick;
      bit          completion;
      running_type job;
      settle_outcomes();
      case (phase)
         0: program_registers(4'd1, 4'd8, 4'd1);
         1: program_registers(4'd0, 4'd3, 4'd0);
         2: program_registers(4'd1, 4'd15, 4'd7);
         4: program_registers(4'd1, 4'd2, 4'd0);
         default: program_registers(CSR_W'($urandom_range(15)), CSR_W'($urandom_range(15)),
                                    CSR_W'($urandom_range(15)));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
         if (n == ITEMS_PER_PHASE / 2)
            settle_outcomes();
         completion = (running_q.size() > 24) ? ($urandom_range(99) < 70)
                                              : ($urandom_range(99) < 40);
         if (completion && running_q.size() != 0 && $urandom_range(99) < 85) begin
            pick = $urandom_range(running_q.size() - 1);
            job  = running_q[pick];
            running_q.delete(pick);
            send_item(lldaf_pkg::MODE_DONE, job.source, job.worker);
         end else if (completion) begin
            send_item(lldaf_pkg::MODE_DONE, pick_source(), 3'($urandom_range(7)));
         end else begin
            send_item(lldaf_pkg::MODE_TASK, pick_source(), 3'($urandom_range(7)));
         end
      end
   endtask

   initial begin
      for (int k = 0; k < POOL_SIZE; k++)
         source_pool[k] = SRC_W'($urandom_range(16'hFFFF));
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(lldaf_pkg::MODE_TASK, 16'h0000, 3'd0);
      send_item(lldaf_pkg::MODE_TASK, 16'hFFFF, 3'd7);
      send_item(lldaf_pkg::MODE_TASK, 16'h0000, 3'd0);
      send_item(lldaf_pkg::MODE_DONE, 16'hFFFF, 3'd7);
      // Fill the affinity table; the last source finds no free entry.
      for (int k = 0; k < 16; k++)
         send_item(lldaf_pkg::MODE_TASK, 16'h0100 + SRC_W'(k), 3'd0);
      settle_outcomes();
      program_registers(4'd0, 4'd8, 4'd1);
      send_item(lldaf_pkg::MODE_TASK, 16'h0000, 3'd0);
      settle_outcomes();
      program_registers(4'd0, 4'd0, 4'd1);
      send_item(lldaf_pkg::MODE_TASK, 16'h2222, 3'd0);
      settle_outcomes();
      program_registers(4'd1, 4'd1, 4'd0);
      send_item(lldaf_pkg::MODE_TASK, 16'h3333, 3'd0);
      send_item(lldaf_pkg::MODE_DONE, 16'h0101, 3'd4);
      settle_outcomes();
      program_registers(4'd1, 4'd15, 4'd7);
      send_item(lldaf_pkg::MODE_TASK, 16'h4444, 3'd0);
      settle_outcomes();
      program_registers(4'd1, 4'd2, 4'd0);
      send_item(lldaf_pkg::MODE_TASK, 16'h0104, 3'd0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 57 : 0;
         recv_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 23 : 0;
         run_phase(phase);
      end

      settle_outcomes();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
